// ===== design/tdfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone digit frame receiver package
// Shared request kinds, symbol codes, reset values and inter-module types.
// ----------------------------------------------------------------------------
package tdfr_pkg;

    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_ARM    = 2'd2;

    localparam logic [3:0] SYM_NONE   = 4'hF;
    localparam logic [3:0] SYM_REPEAT = 4'hE;

    localparam logic [7:0]  OWN_ADDRESS_RST = 8'd0;
    localparam logic [15:0] TIMEOUT_MS_RST  = 16'd400;
    localparam logic [7:0]  GUARD_MS_RST    = 8'd30;
    localparam logic [15:0] IDLE_TICKS_MAX  = 16'hFFFF;

    localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_MS  = 2'd1;
    localparam logic [1:0] REG_GUARD_MS    = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  symbol;
        logic [15:0] ack_cmd;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  own_address;
        logic [15:0] timeout_ms;
        logic [7:0]  guard_ms;
    } cfg_t;

    typedef struct packed {
        logic [7:0] frame_address;
        logic [7:0] cmd_high;
        logic [7:0] cmd_low;
        logic       for_us;
        logic       ack_received;
        logic       send_ack;
    } result_t;

    typedef struct packed {
        logic guard;
        logic pop;
        logic load;
    } back_status_t;

endpackage

// ===== design/tone_digit_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone digit frame receiver
// Collects tone digits into frames, applies timeout and guard timing and
// reports address match and acknowledgement status for each frame.
// ----------------------------------------------------------------------------
// Channel  | Signals            | Contents
// s_axis   | tvalid/tready      | tuser: kind; tdata: symbol, ack_cmd
// m_axis   | tvalid/tready      | tdata: address, command bytes; tuser: flags
// apb      | psel/penable/...   | own_address, timeout_ms, guard_ms
//
// One request is taken per cycle while the queue is not full; the back end
// works it from the four-entry queue when not stalled, and a frame result
// appears in the output register the cycle after its last digit is worked.
// The back end stalls only while a finished result waits in the output
// register and the sink holds tready low; the queue then absorbs up to four
// requests before s_axis_tready falls.
// Reset is asynchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module tone_digit_frame_receiver
#(
    parameter int DIGITS_PER_FRAME = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // symbol [3:0], ack_cmd [19:4], zero fill
    input  logic [1:0]  s_axis_tuser,  // req_type [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // frame_address [7:0], cmd_high [15:8],
                                       // cmd_low [23:16]
    output logic [2:0]  m_axis_tuser,  // for_us [0], ack_received [1], send_ack [2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tdfr_pkg::cfg_t         cfg_reg;
    tdfr_pkg::cfg_t         cfg_next;
    tdfr_pkg::cmd_t         push_cmd;
    tdfr_pkg::cmd_t         head;
    tdfr_pkg::back_status_t status;
    logic                   push;
    logic                   pop;
    logic                   empty;
    logic                   full;
    logic                   wr_en;

    always_comb
    begin
        pready   = 1'b1;
        wr_en    = psel && penable && pwrite && pready;
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                tdfr_pkg::REG_OWN_ADDRESS: cfg_next.own_address = pwdata[7:0];
                tdfr_pkg::REG_TIMEOUT_MS:  cfg_next.timeout_ms  = pwdata[15:0];
                tdfr_pkg::REG_GUARD_MS:    cfg_next.guard_ms    = pwdata[7:0];
                default:
                begin
                end
            endcase
        end
        case (paddr[3:2])
            tdfr_pkg::REG_OWN_ADDRESS: prdata = {24'd0, cfg_reg.own_address};
            tdfr_pkg::REG_TIMEOUT_MS:  prdata = {16'd0, cfg_reg.timeout_ms};
            tdfr_pkg::REG_GUARD_MS:    prdata = {24'd0, cfg_reg.guard_ms};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address <= tdfr_pkg::OWN_ADDRESS_RST;
            cfg_reg.timeout_ms  <= tdfr_pkg::TIMEOUT_MS_RST;
            cfg_reg.guard_ms    <= tdfr_pkg::GUARD_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tdfr_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (full),
        .push          (push),
        .cmd           (push_cmd)
    );

    tdfr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    tdfr_back
    #(
        .DIGITS_PER_FRAME (DIGITS_PER_FRAME)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .status        (status)
    );

    // A request is never queued while the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("request pushed into a full queue");

    // The back end never overwrites a result that the sink has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.pop |-> (!m_axis_tvalid || m_axis_tready))
        else $error("back end advanced over a waiting result");

    // Every completed frame starts the guard time.
    assert property (@(posedge clk) disable iff (!rst_n) status.load |=> status.guard)
        else $error("frame completed without entering guard");

    // A new result is always shown on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) status.load |=> m_axis_tvalid)
        else $error("completed frame not presented");

endmodule

// ===== design/tdfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone digit frame receiver front end
// Accepts requests, drops those that never change state and queues the rest.
// ----------------------------------------------------------------------------
module tdfr_front
(
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,
    input  logic [1:0]         s_axis_tuser,
    input  logic               queue_full,
    output logic               push,
    output tdfr_pkg::cmd_t     cmd
);

    logic keep;

    always_comb
    begin
        keep = ((s_axis_tuser == tdfr_pkg::KIND_SYMBOL) &&
                (s_axis_tdata[3:0] != tdfr_pkg::SYM_NONE)) ||
               (s_axis_tuser == tdfr_pkg::KIND_TICK) ||
               (s_axis_tuser == tdfr_pkg::KIND_ARM);
        s_axis_tready = !queue_full;
        push          = s_axis_tvalid && !queue_full && keep;
        cmd.kind      = s_axis_tuser;
        cmd.symbol    = s_axis_tdata[3:0];
        cmd.ack_cmd   = s_axis_tdata[19:4];
    end

endmodule

// ===== design/tdfr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone digit frame receiver request queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module tdfr_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tdfr_pkg::cmd_t push_cmd,
    input  logic           pop,
    output tdfr_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    tdfr_pkg::cmd_t                  entries_reg [tdfr_pkg::QUEUE_DEPTH];
    logic [tdfr_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [tdfr_pkg::QUEUE_AW-1:0]   wr_ptr_next;
    logic [tdfr_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [tdfr_pkg::QUEUE_AW-1:0]   rd_ptr_next;
    logic [tdfr_pkg::QUEUE_AW:0]     count_reg;
    logic [tdfr_pkg::QUEUE_AW:0]     count_next;

    always_comb
    begin
        empty       = (count_reg == '0);
        full        = (count_reg == (tdfr_pkg::QUEUE_AW+1)'(tdfr_pkg::QUEUE_DEPTH));
        head        = entries_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/tdfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone digit frame receiver back end
// Frame assembly, timeout and guard timing, acknowledgement matching and the
// result register.
// ----------------------------------------------------------------------------
module tdfr_back
#(
    parameter int DIGITS_PER_FRAME = 6
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tdfr_pkg::cfg_t         cfg,
    input  tdfr_pkg::cmd_t         head,
    input  logic                   empty,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [23:0]            m_axis_tdata,
    output logic [2:0]             m_axis_tuser,
    output tdfr_pkg::back_status_t status
);

    localparam int CNT_W = $clog2(DIGITS_PER_FRAME);
    localparam int STORE_DEPTH = DIGITS_PER_FRAME - 1;

    logic [3:0]       digits_reg [STORE_DEPTH];
    logic             guard_reg;
    logic             guard_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [3:0]       last_symbol_reg;
    logic [3:0]       last_symbol_next;
    logic [3:0]       last_digit_reg;
    logic [3:0]       last_digit_next;
    logic             armed_reg;
    logic             armed_next;
    logic [15:0]      idle_ticks_reg;
    logic [15:0]      idle_ticks_next;
    logic [7:0]       guard_ticks_reg;
    logic [7:0]       guard_ticks_next;
    logic             pending_reg;
    logic             pending_next;
    logic [15:0]      expected_reg;
    logic [15:0]      expected_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    tdfr_pkg::result_t out_data_reg;

    logic             out_free;
    logic             sym_take;
    logic             complete;
    logic             load;
    logic [3:0]       digit_new;
    logic [3:0]       frame_digit [6];
    logic             us;
    logic             match;
    tdfr_pkg::result_t result;

    for (genvar g = 0; g < 6; g++)
    begin : g_frame
        if (g < DIGITS_PER_FRAME - 1)
        begin : g_stored
            assign frame_digit[g] = digits_reg[g];
        end
        else if (g == DIGITS_PER_FRAME - 1)
        begin : g_new
            assign frame_digit[g] = digit_new;
        end
        else
        begin : g_zero
            assign frame_digit[g] = 4'h0;
        end
    end

    always_comb
    begin
        out_free  = !out_valid_reg || m_axis_tready;
        pop       = !empty && out_free;
        sym_take  = (head.kind == tdfr_pkg::KIND_SYMBOL) && !guard_reg &&
                    (head.symbol != tdfr_pkg::SYM_NONE) &&
                    (head.symbol != last_symbol_reg);
        digit_new = ((head.symbol == tdfr_pkg::SYM_REPEAT) && (count_reg != '0)) ?
                    last_digit_reg : head.symbol;
        complete  = sym_take && (count_reg == CNT_W'(DIGITS_PER_FRAME - 1));
        load      = pop && complete;

        result.frame_address = {frame_digit[0], frame_digit[1]};
        result.cmd_high      = {frame_digit[2], frame_digit[3]};
        result.cmd_low       = {frame_digit[4], frame_digit[5]};
        us                   = (result.frame_address == cfg.own_address);
        match                = ({result.cmd_high, result.cmd_low} == expected_reg);
        result.for_us        = us;
        result.ack_received  = us && pending_reg && match;
        result.send_ack      = us && !pending_reg;

        guard_next       = guard_reg;
        count_next       = count_reg;
        last_symbol_next = last_symbol_reg;
        last_digit_next  = last_digit_reg;
        armed_next       = armed_reg;
        idle_ticks_next  = idle_ticks_reg;
        guard_ticks_next = guard_ticks_reg;
        pending_next     = pending_reg;
        expected_next    = expected_reg;

        if (pop)
        begin
            case (head.kind)
                tdfr_pkg::KIND_ARM:
                begin
                    pending_next  = 1'b1;
                    expected_next = head.ack_cmd;
                end
                tdfr_pkg::KIND_TICK:
                begin
                    if (guard_reg)
                    begin
                        if (idle_ticks_reg != tdfr_pkg::IDLE_TICKS_MAX)
                        begin
                            idle_ticks_next = idle_ticks_reg + 1'b1;
                        end
                        if (guard_ticks_reg >= cfg.guard_ms)
                        begin
                            guard_next = 1'b0;
                        end
                        else
                        begin
                            guard_ticks_next = guard_ticks_reg + 1'b1;
                        end
                    end
                    else if (armed_reg && (idle_ticks_reg >= cfg.timeout_ms))
                    begin
                        armed_next       = 1'b0;
                        count_next       = '0;
                        last_symbol_next = tdfr_pkg::SYM_NONE;
                    end
                    else if (idle_ticks_reg != tdfr_pkg::IDLE_TICKS_MAX)
                    begin
                        idle_ticks_next = idle_ticks_reg + 1'b1;
                    end
                end
                tdfr_pkg::KIND_SYMBOL:
                begin
                    if (sym_take)
                    begin
                        last_digit_next  = digit_new;
                        last_symbol_next = head.symbol;
                        count_next       = count_reg + 1'b1;
                        armed_next       = 1'b1;
                        idle_ticks_next  = '0;
                        if (complete)
                        begin
                            count_next       = '0;
                            last_symbol_next = tdfr_pkg::SYM_NONE;
                            guard_next       = 1'b1;
                            guard_ticks_next = '0;
                            if (result.ack_received)
                            begin
                                pending_next = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = {out_data_reg.cmd_low, out_data_reg.cmd_high,
                         out_data_reg.frame_address};
        m_axis_tuser  = {out_data_reg.send_ack, out_data_reg.ack_received,
                         out_data_reg.for_us};
        status.guard  = guard_reg;
        status.pop    = pop;
        status.load   = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg       <= 1'b0;
            count_reg       <= '0;
            last_symbol_reg <= tdfr_pkg::SYM_NONE;
            last_digit_reg  <= 4'h0;
            armed_reg       <= 1'b0;
            idle_ticks_reg  <= '0;
            guard_ticks_reg <= '0;
            pending_reg     <= 1'b0;
            expected_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            guard_reg       <= guard_next;
            count_reg       <= count_next;
            last_symbol_reg <= last_symbol_next;
            last_digit_reg  <= last_digit_next;
            armed_reg       <= armed_next;
            idle_ticks_reg  <= idle_ticks_next;
            guard_ticks_reg <= guard_ticks_next;
            pending_reg     <= pending_next;
            expected_reg    <= expected_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
        end
        for (int j = 0; j < STORE_DEPTH; j++)
        begin
            if (pop && sym_take && !complete && (count_reg == CNT_W'(j)))
            begin
                digits_reg[j] <= digit_new;
            end
        end
    end

endmodule

// ===== dv/tb_tone_digit_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone digit frame receiver testbench
// Drives symbol, tick and arm requests into the receiver under six register
// settings and four patterns of source gaps and sink stalls. A scoreboard
// keeps its own model of digit collection, timeout, guard and acknowledgement
// handling, and checks every frame result field by field in order.
// ----------------------------------------------------------------------------
module tb_tone_digit_frame_receiver;

    localparam int         FRAME_DIGITS = 6;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 2000000;
    localparam int         DRAIN_CYCLES = 12;

    class frame_scoreboard;
        logic [7:0]        own_addr;
        logic [15:0]       timeout_lim;
        logic [7:0]        guard_lim;
        bit                in_guard;
        int unsigned       n_digits;
        logic [3:0]        last_sym;
        logic [3:0]        digit_store [FRAME_DIGITS];
        bit                armed;
        logic [15:0]       idle_cnt;
        logic [7:0]        guard_cnt;
        bit                ack_wait;
        logic [15:0]       ack_cmd_exp;
        tdfr_pkg::result_t pending [$];
        int unsigned       n_errors;
        int unsigned       n_checked;
        int unsigned       n_ours;
        int unsigned       n_acks;
        int unsigned       n_echoes;
        int unsigned       n_timeouts;

        function new();
            own_addr    = tdfr_pkg::OWN_ADDRESS_RST;
            timeout_lim = tdfr_pkg::TIMEOUT_MS_RST;
            guard_lim   = tdfr_pkg::GUARD_MS_RST;
            in_guard    = 1'b0;
            n_digits    = 0;
            last_sym    = tdfr_pkg::SYM_NONE;
            foreach (digit_store[k])
                digit_store[k] = 4'd0;
            armed       = 1'b0;
            idle_cnt    = 16'd0;
            guard_cnt   = 8'd0;
            ack_wait    = 1'b0;
            ack_cmd_exp = 16'd0;
            n_errors    = 0;
            n_checked   = 0;
            n_ours      = 0;
            n_acks      = 0;
            n_echoes    = 0;
            n_timeouts  = 0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [31:0] val);
            case (idx)
                tdfr_pkg::REG_OWN_ADDRESS: own_addr    = val[7:0];
                tdfr_pkg::REG_TIMEOUT_MS:  timeout_lim = val[15:0];
                tdfr_pkg::REG_GUARD_MS:    guard_lim   = val[7:0];
                default: ;
            endcase
        endfunction

        function void note_request(input logic [1:0] kind, input logic [3:0] sym,
                                   input logic [15:0] cmd);
            logic [3:0]        d;
            tdfr_pkg::result_t r;
            if (kind == tdfr_pkg::KIND_ARM)
            begin
                ack_wait    = 1'b1;
                ack_cmd_exp = cmd;
            end
            else if (kind == tdfr_pkg::KIND_TICK)
            begin
                if (in_guard)
                begin
                    if (idle_cnt != tdfr_pkg::IDLE_TICKS_MAX)
                        idle_cnt++;
                    if (guard_cnt >= guard_lim)
                        in_guard = 1'b0;
                    else
                        guard_cnt++;
                end
                else if (armed && idle_cnt >= timeout_lim)
                begin
                    armed    = 1'b0;
                    n_digits = 0;
                    last_sym = tdfr_pkg::SYM_NONE;
                    n_timeouts++;
                end
                else if (idle_cnt != tdfr_pkg::IDLE_TICKS_MAX)
                begin
                    idle_cnt++;
                end
            end
            else if (kind == tdfr_pkg::KIND_SYMBOL && !in_guard &&
                     sym != tdfr_pkg::SYM_NONE && sym != last_sym)
            begin
                d = (sym == tdfr_pkg::SYM_REPEAT && n_digits > 0) ?
                    digit_store[n_digits - 1] : sym;
                digit_store[n_digits] = d;
                last_sym = sym;
                n_digits++;
                armed    = 1'b1;
                idle_cnt = 16'd0;
                if (n_digits == FRAME_DIGITS)
                begin
                    r.frame_address = {digit_store[0], digit_store[1]};
                    r.cmd_high      = {digit_store[2], digit_store[3]};
                    r.cmd_low       = {digit_store[4], digit_store[5]};
                    r.for_us        = (r.frame_address == own_addr);
                    r.ack_received  = 1'b0;
                    r.send_ack      = 1'b0;
                    n_digits  = 0;
                    last_sym  = tdfr_pkg::SYM_NONE;
                    in_guard  = 1'b1;
                    guard_cnt = 8'd0;
                    if (r.for_us)
                    begin
                        if (!ack_wait)
                        begin
                            r.send_ack = 1'b1;
                        end
                        else if ({r.cmd_high, r.cmd_low} == ack_cmd_exp)
                        begin
                            ack_wait       = 1'b0;
                            r.ack_received = 1'b1;
                        end
                    end
                    pending.push_back(r);
                end
            end
        endfunction

        task report_mismatch(input string what, input logic [31:0] got,
                             input logic [31:0] want);
            $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
            n_errors++;
        endtask

        task check_result(input logic [23:0] data, input logic [2:0] flags);
            tdfr_pkg::result_t exp;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected frame result", {5'd0, flags, data}, 32'd0);
            end
            else
            begin
                exp = pending.pop_front();
                n_checked++;
                if (exp.for_us)
                    n_ours++;
                if (exp.ack_received)
                    n_acks++;
                if (exp.send_ack)
                    n_echoes++;
                if (data[7:0] !== exp.frame_address)
                    report_mismatch("frame_address", 32'(data[7:0]),
                                    32'(exp.frame_address));
                if (data[15:8] !== exp.cmd_high)
                    report_mismatch("cmd_high", 32'(data[15:8]), 32'(exp.cmd_high));
                if (data[23:16] !== exp.cmd_low)
                    report_mismatch("cmd_low", 32'(data[23:16]), 32'(exp.cmd_low));
                if (flags[0] !== exp.for_us)
                    report_mismatch("for_us", 32'(flags[0]), 32'(exp.for_us));
                if (flags[1] !== exp.ack_received)
                    report_mismatch("ack_received", 32'(flags[1]),
                                    32'(exp.ack_received));
                if (flags[2] !== exp.send_ack)
                    report_mismatch("send_ack", 32'(flags[2]), 32'(exp.send_ack));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;
    logic [1:0]  s_axis_tuser  = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = 4'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb;
    int unsigned     send_idle_pct = 0;
    int unsigned     stall_pct     = 0;
    int unsigned     n_sent        = 0;
    int unsigned     cycle_cnt     = 0;

    tone_digit_frame_receiver #(
        .DIGITS_PER_FRAME(FRAME_DIGITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Called at a falling edge; the request stays valid until the next call
    // or until the source is explicitly idled.
    task automatic send_req(input logic [1:0] kind, input logic [3:0] sym,
                            input logic [15:0] cmd);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'd0, cmd, sym};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(kind, sym, cmd);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send_symbol(input logic [3:0] sym);
        send_req(tdfr_pkg::KIND_SYMBOL, sym, 16'($urandom));
    endtask

    task automatic send_tick();
        send_req(tdfr_pkg::KIND_TICK, 4'($urandom), 16'($urandom));
    endtask

    task automatic send_arm(input logic [15:0] cmd);
        send_req(tdfr_pkg::KIND_ARM, 4'($urandom), cmd);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_tick();
    endtask

    task automatic leave_guard();
        while (sb.in_guard)
        begin
            if ($urandom_range(0, 99) < 15)
                send_symbol(4'($urandom));
            send_tick();
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] own, input logic [15:0] tmo,
                             input logic [7:0] grd);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        apb_write(tdfr_pkg::REG_OWN_ADDRESS, {24'd0, own});
        apb_write(tdfr_pkg::REG_TIMEOUT_MS, {16'd0, tmo});
        apb_write(tdfr_pkg::REG_GUARD_MS, {24'd0, grd});
    endtask

    // Turns the wanted digits into tone symbols: a digit equal to its
    // predecessor goes as repeat, or as itself after a repeat; digits that
    // cannot be stored (no tone, repeat past the first place) are randomized.
    task automatic send_frame(input logic [7:0] addr, input logic [15:0] cmd,
                              input bit noisy);
        logic [3:0]  want [FRAME_DIGITS];
        logic [3:0]  d;
        logic [3:0]  raw;
        logic [3:0]  prev_d;
        logic [3:0]  prev_raw;
        int unsigned gap_max;
        want     = '{addr[7:4], addr[3:0], cmd[15:12], cmd[11:8], cmd[7:4], cmd[3:0]};
        prev_d   = 4'd0;
        prev_raw = tdfr_pkg::SYM_NONE;
        gap_max  = (sb.timeout_lim < 16'd3) ? sb.timeout_lim : 3;
        for (int k = 0; k < FRAME_DIGITS; k++)
        begin
            d = want[k];
            if (d == tdfr_pkg::SYM_NONE || (k > 0 && d == tdfr_pkg::SYM_REPEAT))
                d = 4'($urandom_range(0, 13));
            if (k > 0 && d == prev_d)
                raw = (prev_raw == tdfr_pkg::SYM_REPEAT) ? d : tdfr_pkg::SYM_REPEAT;
            else
                raw = d;
            if (k > 0)
            begin
                send_ticks($urandom_range(0, gap_max));
                if (noisy && $urandom_range(0, 99) < 25)
                    send_symbol($urandom_range(0, 1) ? prev_raw : tdfr_pkg::SYM_NONE);
            end
            send_symbol(raw);
            prev_d   = d;
            prev_raw = raw;
        end
    endtask

    task automatic random_block();
        int unsigned pick;
        logic [7:0]  addr;
        logic [15:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            leave_guard();
            if (sb.timeout_lim <= 16'd64)
            begin
                while (sb.n_digits != 0)
                    send_tick();
            end
            if ($urandom_range(0, 99) < 20)
                send_arm(16'($urandom));
            addr = ($urandom_range(0, 99) < 70) ? sb.own_addr : 8'($urandom);
            cmd  = (sb.ack_wait && $urandom_range(0, 99) < 60) ? sb.ack_cmd_exp
                                                                 : 16'($urandom);
            send_frame(addr, cmd, $urandom_range(0, 99) < 30);
        end
        else if (pick < 68)
        begin
            case ($urandom_range(0, 3))
                0:       send_arm(16'h0000);
                1:       send_arm(16'hFFFF);
                default: send_arm(16'($urandom));
            endcase
        end
        else if (pick < 80)
        begin
            repeat ($urandom_range(1, 6))
                send_req(2'($urandom), 4'($urandom), 16'($urandom));
        end
        else if (pick < 92)
        begin
            repeat ($urandom_range(1, FRAME_DIGITS - 1))
                send_symbol(4'($urandom));
            if (sb.timeout_lim <= 16'd64)
                send_ticks(sb.timeout_lim + 1 + $urandom_range(0, 2));
            else
                send_ticks($urandom_range(1, 8));
        end
        else
        begin
            send_ticks($urandom_range(1, (sb.timeout_lim <= 16'd32) ?
                                         2 * sb.timeout_lim : 64));
        end
    endtask

    task automatic random_items(input int unsigned budget);
        int unsigned start;
        start = n_sent;
        while (n_sent - start < budget)
            random_block();
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        configure(8'h12, 16'd3, 8'd1);
        send_req(KIND_UNUSED, 4'hF, 16'hFFFF);
        send_arm(16'hFFFF);
        send_arm(16'h3456);
        // Repeat symbol first is stored as such; duplicates and no tone drop.
        send_symbol(tdfr_pkg::SYM_REPEAT);
        send_symbol(tdfr_pkg::SYM_REPEAT);
        send_symbol(tdfr_pkg::SYM_NONE);
        send_symbol(4'h1);
        send_symbol(4'h1);
        send_symbol(4'h0);
        send_symbol(tdfr_pkg::SYM_REPEAT);
        send_symbol(4'h3);
        send_symbol(4'h4);
        send_symbol(4'h5);
        send_ticks(2);
        send_symbol(4'h1);
        send_symbol(4'h2);
        send_symbol(4'h3);
        send_symbol(4'h4);
        send_symbol(4'h5);
        send_symbol(4'h6);
        send_ticks(2);
        send_symbol(4'h0);
        send_ticks(4);

        configure(8'h00, 16'd1, 8'd0);
        random_items(280);

        send_idle_pct = 54;
        configure(8'h5D, 16'd6, 8'd2);
        random_items(280);

        send_idle_pct = 0;
        stall_pct     = 54;
        configure(8'hE1, 16'd40, 8'd9);
        random_items(280);

        send_idle_pct = 36;
        stall_pct     = 36;
        configure(8'hA7, 16'd12, 8'd4);
        random_items(280);

        send_idle_pct = 0;
        stall_pct     = 0;
        leave_guard();
        configure(8'hFF, 16'hFFFF, 8'hFF);
        send_frame(8'($urandom), 16'($urandom), 1'b0);
        leave_guard();
        send_symbol(4'h7);
        send_symbol(4'h2);
        send_symbol(4'h9);
        send_ticks(5);
        send_frame(8'hFF, 16'($urandom), 1'b0);

        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests under six register settings; %0d frames checked.",
                 n_sent, sb.n_checked);
        $display("Timeouts %0d, frames for this node %0d, acks matched %0d, echoes %0d.",
                 sb.n_timeouts, sb.n_ours, sb.n_acks, sb.n_echoes);
        if (sb.n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
design/tdfr_pkg.sv
design/tdfr_front.sv
design/tdfr_queue.sv
design/tdfr_back.sv
design/tone_digit_frame_receiver.sv
dv/tb_tone_digit_frame_receiver.sv
